@@ rtl/core/trd_pkg.sv @@
// Shared types and constants for the thumbstick radial dead zone pipeline.
// No dependencies.
package trd_pkg;

    localparam int FRACTION_BITS_DEF = 15;
    localparam int DIV_STEPS = 17;
    localparam int DIV_LANES = 3;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_S = 2;

    localparam logic [14:0] DEAD_ZONE_RESET = 15'd7849;
    localparam logic [14:0] FULL_RAW = 15'd32767;
    localparam logic signed [32:0] HALF_ROOT_Q30 = 33'sd759250124;

    typedef enum logic [2:0] {
        HEAD_NONE  = 3'd0,
        HEAD_UP    = 3'd1,
        HEAD_DOWN  = 3'd2,
        HEAD_LEFT  = 3'd3,
        HEAD_RIGHT = 3'd4
    } heading_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic live;
    } trd_samp_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic root_zero;
        logic s_full;
        logic s_zero;
    } trd_flags_t;

endpackage

@@ rtl/core/trd_sqrt.sv @@
// Pipelined digit-by-digit square root, one result bit per stage.
// Depends on trd_pkg.
module trd_sqrt
    import trd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int RW = 16 + FRACTION_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   m2,
    input  trd_samp_t     in_samp,
    output logic          out_valid,
    output logic [RW-1:0] root,
    output trd_samp_t     out_samp
);

    logic [RW+2:0] rem_st  [0:RW];
    logic [RW-1:0] root_st [0:RW];
    logic [31:0]   rad_st  [0:RW];
    logic          v_st    [0:RW];
    trd_samp_t     samp_st [0:RW];

    assign rem_st[0]  = '0;
    assign root_st[0] = '0;
    assign rad_st[0]  = m2;
    assign v_st[0]    = in_valid;
    assign samp_st[0] = in_samp;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+2:0] rem_sh;
        logic [RW+2:0] trial;
        logic          ge;
        logic [RW+2:0] rem_next;
        logic [RW-1:0] root_next;

        always_comb begin
            rem_sh    = {rem_st[k][RW:0], rad_st[k][31:30]};
            trial     = {1'b0, root_st[k], 2'b01};
            ge        = rem_sh >= trial;
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_st[k][RW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_st[k+1] <= 1'b0;
            end else if (en) begin
                v_st[k+1] <= v_st[k];
            end
            if (en) begin
                rem_st[k+1]  <= rem_next;
                root_st[k+1] <= root_next;
                rad_st[k+1]  <= {rad_st[k][29:0], 2'b00};
                samp_st[k+1] <= samp_st[k];
            end
        end
    end

    assign out_valid = v_st[RW];
    assign root      = root_st[RW];
    assign out_samp  = samp_st[RW];

endmodule

@@ rtl/core/trd_div.sv @@
// Pipelined restoring divider, several lanes side by side, one quotient bit per stage.
// Depends on trd_pkg.
module trd_div
    import trd_pkg::*;
#(
    parameter int DW = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DW-1:0]        num  [DIV_LANES],
    input  logic [DW-1:0]        den  [DIV_LANES],
    input  trd_flags_t           in_flags,
    output logic                 out_valid,
    output logic [DIV_STEPS-1:0] quo  [DIV_LANES],
    output trd_flags_t           out_flags
);

    logic [DW-1:0]        rem_st [0:DIV_STEPS][DIV_LANES];
    logic [DW-1:0]        den_st [0:DIV_STEPS][DIV_LANES];
    logic [DIV_STEPS-1:0] q_st   [0:DIV_STEPS][DIV_LANES];
    logic                 v_st   [0:DIV_STEPS];
    trd_flags_t           f_st   [0:DIV_STEPS];

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_in
        assign rem_st[0][l] = num[l];
        assign den_st[0][l] = den[l];
        assign q_st[0][l]   = '0;
        assign quo[l]       = q_st[DIV_STEPS][l];
    end
    assign v_st[0] = in_valid;
    assign f_st[0] = in_flags;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_st[k+1] <= 1'b0;
            end else if (en) begin
                v_st[k+1] <= v_st[k];
            end
            if (en) begin
                f_st[k+1] <= f_st[k];
            end
        end

        for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
            logic [DW:0]   rem_sh;
            logic          ge;
            logic [DW-1:0] rem_next;

            always_comb begin
                rem_sh   = {rem_st[k][l], 1'b0};
                ge       = rem_sh >= {1'b0, den_st[k][l]};
                rem_next = ge ? DW'(rem_sh - {1'b0, den_st[k][l]}) : rem_sh[DW-1:0];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_st[k+1][l] <= rem_next;
                    den_st[k+1][l] <= den_st[k][l];
                    q_st[k+1][l]   <= {q_st[k][l][DIV_STEPS-2:0], ge};
                end
            end
        end
    end

    assign out_valid = v_st[DIV_STEPS];
    assign out_flags = f_st[DIV_STEPS];

endmodule

@@ rtl/core/trd_head.sv @@
// Output stages: saturation of the unit vector, strength select, heading class.
// Depends on trd_pkg.
module trd_head
    import trd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIV_STEPS-1:0]  quo [DIV_LANES],
    input  trd_flags_t            flags,
    output logic                  out_valid,
    output logic signed [15:0]    unit_x,
    output logic signed [15:0]    unit_y,
    output logic [15:0]           strength,
    output heading_t              heading
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [15:0] ux1_reg, uy1_reg, ux2_reg, uy2_reg, ux3_reg, uy3_reg;
    logic [15:0]        s1_reg, s2_reg, s3_reg;
    logic signed [32:0] px_reg, py_reg;
    heading_t           h3_reg;

    logic signed [15:0] ux_next, uy_next;
    logic [15:0]        s_next;
    heading_t           h_next;

    function automatic logic signed [15:0] sat_unit(input logic neg, input logic zero,
                                                    input logic [DIV_STEPS-1:0] q);
        logic signed [15:0] r;
        if (zero) begin
            r = '0;
        end else if (neg) begin
            r = (q > DIV_STEPS'(32768)) ? 16'sh8000 : 16'(-q);
        end else begin
            r = (q > DIV_STEPS'(32767)) ? 16'sh7fff : 16'(q);
        end
        return r;
    endfunction

    always_comb begin
        ux_next = sat_unit(flags.x_neg, flags.root_zero, quo[LANE_X]);
        uy_next = sat_unit(flags.y_neg, flags.root_zero, quo[LANE_Y]);
        if (flags.s_full) begin
            s_next = 16'd32768;
        end else if (flags.s_zero) begin
            s_next = '0;
        end else begin
            s_next = {1'b0, quo[LANE_S][16:2]};
        end
        if (px_reg > HALF_ROOT_Q30) begin
            h_next = HEAD_RIGHT;
        end else if (px_reg < -HALF_ROOT_Q30) begin
            h_next = HEAD_LEFT;
        end else if (py_reg > HALF_ROOT_Q30) begin
            h_next = HEAD_UP;
        end else if (py_reg < -HALF_ROOT_Q30) begin
            h_next = HEAD_DOWN;
        end else begin
            h_next = HEAD_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            ux1_reg <= ux_next;
            uy1_reg <= uy_next;
            s1_reg  <= s_next;
            px_reg  <= ux1_reg * $signed({1'b0, s1_reg});
            py_reg  <= uy1_reg * $signed({1'b0, s1_reg});
            ux2_reg <= ux1_reg;
            uy2_reg <= uy1_reg;
            s2_reg  <= s1_reg;
            ux3_reg <= ux2_reg;
            uy3_reg <= uy2_reg;
            s3_reg  <= s2_reg;
            h3_reg  <= h_next;
        end
    end

    assign out_valid = v3_reg;
    assign unit_x    = ux3_reg;
    assign unit_y    = uy3_reg;
    assign strength  = s3_reg;
    assign heading   = h3_reg;

endmodule

@@ rtl/core/thumbstick_radial_deadzone.sv @@
// Throughput: one transfer per cycle; all stages advance together while the
// output register is empty or being taken.
// Reset (aresetn low, synchronous): pipeline emptied, dead_zone back to 7849.
// Depends on trd_pkg, trd_sqrt, trd_div, trd_head.
module thumbstick_radial_deadzone
    import trd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stick_x[15:0], stick_y[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // unit_x[15:0], unit_y[31:16], strength[47:32],
                                   // heading[50:48], zero[55:51]
);

    localparam int RW = 16 + FRACTION_BITS;

    logic               en;
    logic [14:0]        dz_reg;
    logic [29:0]        dzsq_reg;
    logic               va_reg, vb_reg;
    logic signed [15:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [31:0]        xx_reg, yy_reg, m2_reg;
    logic               live_reg;

    trd_samp_t   b_samp, r_samp;
    logic        r_valid;
    logic [RW-1:0] root;

    logic [RW-1:0] dzq, full, magc, den, dd;
    logic [15:0]   magx, magy;
    logic [RW-1:0] num [DIV_LANES];
    logic [RW-1:0] dvs [DIV_LANES];
    trd_flags_t    d_flags, q_flags;
    logic          q_valid;
    logic [DIV_STEPS-1:0] quo [DIV_LANES];

    logic signed [15:0] unit_x, unit_y;
    logic [15:0]        strength;
    heading_t           heading;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg <= DEAD_ZONE_RESET;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                dz_reg <= cfg_wdata;
            end
            if (en) begin
                va_reg <= s_tvalid;
                vb_reg <= va_reg;
            end
        end
        dzsq_reg <= dz_reg * dz_reg;
        if (en) begin
            xa_reg   <= s_tdata[15:0];
            ya_reg   <= s_tdata[31:16];
            xx_reg   <= 32'($signed(s_tdata[15:0]) * $signed(s_tdata[15:0]));
            yy_reg   <= 32'($signed(s_tdata[31:16]) * $signed(s_tdata[31:16]));
            xb_reg   <= xa_reg;
            yb_reg   <= ya_reg;
            m2_reg   <= xx_reg + yy_reg;
            live_reg <= (xx_reg + yy_reg) > {2'b00, dzsq_reg};
        end
    end

    assign b_samp = '{x: xb_reg, y: yb_reg, live: live_reg};

    trd_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vb_reg),
        .m2        (m2_reg),
        .in_samp   (b_samp),
        .out_valid (r_valid),
        .root      (root),
        .out_samp  (r_samp)
    );

    always_comb begin
        magx = r_samp.x[15] ? 16'(-r_samp.x) : 16'(r_samp.x);
        magy = r_samp.y[15] ? 16'(-r_samp.y) : 16'(r_samp.y);
        dzq  = RW'(dz_reg) << FRACTION_BITS;
        full = RW'(FULL_RAW) << FRACTION_BITS;
        magc = (root > full) ? full : root;
        den  = full - dzq;
        dd   = magc - dzq;
        d_flags.x_neg     = r_samp.x[15];
        d_flags.y_neg     = r_samp.y[15];
        d_flags.root_zero = (root == '0);
        d_flags.s_full    = r_samp.live && ((den == '0) || ((magc > dzq) && (dd == den)));
        d_flags.s_zero    = !r_samp.live || (magc <= dzq);
        num[LANE_X] = RW'(magx) << (FRACTION_BITS - 2);
        num[LANE_Y] = RW'(magy) << (FRACTION_BITS - 2);
        num[LANE_S] = dd;
        dvs[LANE_X] = d_flags.root_zero ? RW'(1) : root;
        dvs[LANE_Y] = d_flags.root_zero ? RW'(1) : root;
        dvs[LANE_S] = (den == '0) ? RW'(1) : den;
    end

    trd_div #(.DW(RW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .num       (num),
        .den       (dvs),
        .in_flags  (d_flags),
        .out_valid (q_valid),
        .quo       (quo),
        .out_flags (q_flags)
    );

    trd_head u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .quo       (quo),
        .flags     (q_flags),
        .out_valid (m_tvalid),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .strength  (strength),
        .heading   (heading)
    );

    assign m_tdata = {5'b00000, heading, strength, unit_y, unit_x};

endmodule

@@ rtl/core/trd_checker.sv @@
// Port-level checks for thumbstick_radial_deadzone, bound to the top level.
// Depends on trd_pkg.
module trd_props
    import trd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transfer changed while stalled");

    ap_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready not tied to output drain");

    ap_str_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:32] <= 16'd32768)
        else $error("strength above full scale");

    ap_no_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[47:32] == '0) |-> m_tdata[50:48] == HEAD_NONE)
        else $error("heading without strength");

    ap_zero_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] == '0) |-> m_tdata[47:32] == '0)
        else $error("strength with zero direction");

endmodule

bind thumbstick_radial_deadzone trd_props u_trd_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/trd_checker.sv @@
// Predicts and checks each result of the radial dead zone block.
// Depends on trd_pkg; watches both stream channels and the register write port.
`timescale 1ns / 1ps
module trd_checker
    import trd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    typedef struct {
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic [15:0]        strength;
        heading_t           heading;
    } stick_result_t;

    stick_result_t want_q[$];
    logic [14:0] radius;

    function automatic logic [63:0] root_q15(input logic [63:0] m2);
        logic [63:0] rem, root, trial, pair;
        rem = 0;
        root = 0;
        for (int i = 0; i < 31; i++) begin
            pair = (i < 16) ? ((m2 >> (30 - 2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [15:0] unit_of(input longint v, input logic [63:0] root);
        logic [63:0] mag, q;
        if (root == 0) return 16'sd0;
        mag = (v < 0) ? -v : v;
        q = (mag << 30) / root;
        if (v < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    function automatic stick_result_t deadzone_predict(input logic [31:0] d, input logic [14:0] dz);
        stick_result_t r;
        longint x, y, px, py;
        logic [63:0] m2, root, full, dzq, magc, st;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        m2 = x * x + y * y;
        root = (m2 == 0) ? 64'd0 : root_q15(m2);
        r.unit_x = unit_of(x, root);
        r.unit_y = unit_of(y, root);
        st = 0;
        if (m2 > 64'(dz) * 64'(dz)) begin
            full = 64'd32767 << 15;
            dzq = 64'(dz) << 15;
            magc = (root > full) ? full : root;
            if (full == dzq) st = 32768;
            else if (magc <= dzq) st = 0;
            else begin
                st = ((magc - dzq) << 15) / (full - dzq);
                if (st > 32768) st = 32768;
            end
        end
        r.strength = st[15:0];
        r.heading = HEAD_NONE;
        if (st != 0) begin
            px = longint'(r.unit_x) * longint'(st);
            py = longint'(r.unit_y) * longint'(st);
            if (px > 759250124) r.heading = HEAD_RIGHT;
            else if (px < -759250124) r.heading = HEAD_LEFT;
            else if (py > 759250124) r.heading = HEAD_UP;
            else if (py < -759250124) r.heading = HEAD_DOWN;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want, result_count);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        stick_result_t w;
        if (!aresetn) begin
            radius <= DEAD_ZONE_RESET;
        end else begin
            if (cfg_wen) radius <= cfg_wdata;
            if (s_tvalid && s_tready) want_q.push_back(deadzone_predict(s_tdata, radius));
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    w = want_q.pop_front();
                    if (m_tdata[15:0] !== w.unit_x)
                        report_mismatch("unit_x", $signed(m_tdata[15:0]), w.unit_x);
                    if (m_tdata[31:16] !== w.unit_y)
                        report_mismatch("unit_y", $signed(m_tdata[31:16]), w.unit_y);
                    if (m_tdata[47:32] !== w.strength)
                        report_mismatch("strength", m_tdata[47:32], w.strength);
                    if (m_tdata[50:48] !== w.heading)
                        report_mismatch("heading", m_tdata[50:48], w.heading);
                end
                result_count++;
            end
        end
        pending = want_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for thumbstick_radial_deadzone; trd_checker does the checking.
// Depends on trd_pkg, the block under test and tb/trd_checker.sv.
`timescale 1ns / 1ps
module testbench;
    import trd_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wen = 0;
    logic [14:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    int fail_count, pending, result_count;
    int send_idle, recv_stall, sent;

    always #1 aclk = ~aclk;

    thumbstick_radial_deadzone u_dut (.*);
    trd_checker u_chk (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic send_stick(input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {y, x};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain_and_set(input logic [14:0] dz);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wen <= 1;
        cfg_wdata <= dz;
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] ends[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A82};
        sent = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            send_stick(ends[i], ends[(i + 2) % 6]);
            send_stick(ends[(i + 3) % 6], ends[i]);
        end
        send_stick(16'd7849, 0);
        send_stick(16'd7850, 0);
        send_stick(0, 16'd7850);
        send_stick(0, -16'sd7850);
        send_stick(-16'sd7850, 0);
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 58; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 58; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            case (ph)
                0: drain_and_set(15'd0);
                1: drain_and_set(15'd32766);
                2: drain_and_set(15'd32767);
                3: drain_and_set(15'd1);
                4: drain_and_set(DEAD_ZONE_RESET);
                default: drain_and_set(15'($urandom_range(32767)));
            endcase
            for (int k = 0; k < 230; k++) send_stick(pick_axis(), pick_axis());
        end
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("sent %0d stick samples over 8 dead zone settings, %0d results checked",
                 sent, result_count);
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
